@@ hw/rtl/spt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream prefetch tracker package
// Shared widths, codes and the request record passed from the tracker table
// to the prefetch issue stage.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int unsigned ADDR_W          = 64;
  localparam int unsigned MAX_TRACKERS    = 16;
  localparam int unsigned PAGE_SHIFT      = 12;
  localparam int unsigned BLOCK_SHIFT     = 6;
  localparam int unsigned MAX_DEGREE      = 16;

  localparam int unsigned PAGE_W          = ADDR_W - PAGE_SHIFT;
  localparam int unsigned OFF_W           = PAGE_SHIFT - BLOCK_SHIFT;
  localparam int unsigned BLOCKS_PER_PAGE = 1 << OFF_W;
  localparam int unsigned IDX_W           = (MAX_TRACKERS > 1) ? $clog2(MAX_TRACKERS) : 1;
  localparam int unsigned RANK_W          = IDX_W;
  localparam int unsigned CNT_W           = $clog2(MAX_TRACKERS + 1);
  localparam int unsigned DEG_W           = $clog2(MAX_DEGREE + 1);

  localparam int unsigned CFG_W           = 5;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned REG_IDX_W       = PADDR_W - 2;

  localparam logic [CFG_W-1:0] ACTIVE_TRACKERS_RST = CFG_W'(16);
  localparam logic [CFG_W-1:0] PREFETCH_DEGREE_RST = CFG_W'(4);

  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ACTIVE_TRACKERS = 1'b0,
    REG_PREFETCH_DEGREE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  off;
    dir_e              dir;
    logic [DEG_W-1:0]  count;
  } run_cmd_t;

endpackage

@@ hw/rtl/spt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream prefetch tracker front end
// Accepts a demand request, matches its page against the tracker table,
// updates the table in LRU order and hands confirmed stream runs onward.
// ----------------------------------------------------------------------------
module spt_front import spt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADDR_W-1:0] access_address_i,
  input  logic [CFG_W-1:0]  active_trackers_i,
  input  logic [CFG_W-1:0]  prefetch_degree_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output run_cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } front_state_e;

  front_state_e state_q, state_d;

  logic [ADDR_W-1:0]       addr_q;
  logic [MAX_TRACKERS-1:0] ent_valid_q, ent_valid_d;
  logic [RANK_W-1:0]       ent_rank_q [MAX_TRACKERS];
  logic [RANK_W-1:0]       ent_rank_d [MAX_TRACKERS];
  logic [PAGE_W-1:0]       ent_page_q [MAX_TRACKERS];
  logic [OFF_W-1:0]        ent_last_q [MAX_TRACKERS];
  dir_e                    ent_dir_q  [MAX_TRACKERS];
  logic [CNT_W-1:0]        count_q, count_d;

  logic [PAGE_W-1:0]       acc_page;
  logic [OFF_W-1:0]        acc_off;
  logic                    hit;
  logic [IDX_W-1:0]        hit_idx;
  logic                    old_found;
  logic [IDX_W-1:0]        old_idx;
  logic [CNT_W-1:0]        limit;
  logic                    do_evict;
  logic [MAX_TRACKERS-1:0] valid_after;
  logic [IDX_W-1:0]        ins_idx;
  logic [RANK_W-1:0]       ins_rank;
  logic [OFF_W-1:0]        hit_last;
  dir_e                    hit_dir;
  logic [RANK_W-1:0]       hit_rank;
  logic                    same_off;
  dir_e                    new_dir;
  logic [OFF_W-1:0]        avail;
  logic [DEG_W-1:0]        deg;
  logic [DEG_W-1:0]        run_cnt;
  logic                    do_run;
  logic                    accept;
  logic                    stall;
  logic                    commit;

  assign acc_page = addr_q[ADDR_W-1:PAGE_SHIFT];
  assign acc_off  = addr_q[PAGE_SHIFT-1:BLOCK_SHIFT];

  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    old_found = 1'b0;
    old_idx   = '0;
    for (int i = MAX_TRACKERS - 1; i >= 0; i--) begin
      if (ent_valid_q[i] && (ent_page_q[i] == acc_page)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (ent_valid_q[i] && (ent_rank_q[i] == '0)) begin
        old_found = 1'b1;
        old_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (32'(active_trackers_i) > 32'(MAX_TRACKERS)) begin
      limit = CNT_W'(MAX_TRACKERS);
    end else if (active_trackers_i == '0) begin
      limit = CNT_W'(1);
    end else begin
      limit = CNT_W'(active_trackers_i);
    end
  end

  assign do_evict = (count_q >= limit) && old_found;
  assign ins_rank = RANK_W'(count_q - CNT_W'(do_evict));

  always_comb begin
    ins_idx = '0;
    for (int i = 0; i < MAX_TRACKERS; i++) begin
      valid_after[i] = ent_valid_q[i] && !(do_evict && (old_idx == IDX_W'(i)));
    end
    for (int i = MAX_TRACKERS - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        ins_idx = IDX_W'(i);
      end
    end
  end

  assign hit_last = ent_last_q[hit_idx];
  assign hit_dir  = ent_dir_q[hit_idx];
  assign hit_rank = ent_rank_q[hit_idx];
  assign same_off = (acc_off == hit_last);
  assign new_dir  = (acc_off > hit_last) ? DIR_UP : DIR_DOWN;
  assign avail    = (new_dir == DIR_UP) ? (OFF_W'(BLOCKS_PER_PAGE - 1) - acc_off) : acc_off;

  always_comb begin
    if (32'(prefetch_degree_i) > 32'(MAX_DEGREE)) begin
      deg = DEG_W'(MAX_DEGREE);
    end else begin
      deg = DEG_W'(prefetch_degree_i);
    end
    if (32'(avail) < 32'(deg)) begin
      run_cnt = DEG_W'(avail);
    end else begin
      run_cnt = deg;
    end
  end

  assign do_run = hit && !same_off && (new_dir == hit_dir) && (run_cnt != '0);
  assign accept = in_valid_i && in_ready_o;
  assign stall  = (state_q == ST_LOOK) && do_run && !cmd_ready_i;
  assign commit = (state_q == ST_LOOK) && !stall;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cmd_valid_o = (state_q == ST_LOOK) && do_run;
  assign cmd_o.page  = acc_page;
  assign cmd_o.off   = acc_off;
  assign cmd_o.dir   = new_dir;
  assign cmd_o.count = run_cnt;

  always_comb begin
    state_d     = state_q;
    ent_valid_d = ent_valid_q;
    ent_rank_d  = ent_rank_q;
    count_d     = count_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK: if (!stall) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (commit) begin
      if (!hit) begin
        for (int i = 0; i < MAX_TRACKERS; i++) begin
          if (do_evict && ent_valid_q[i] && (ent_rank_q[i] != '0)) begin
            ent_rank_d[i] = ent_rank_q[i] - 1'b1;
          end
        end
        if (do_evict) begin
          ent_valid_d[old_idx] = 1'b0;
        end
        ent_valid_d[ins_idx] = 1'b1;
        ent_rank_d[ins_idx]  = ins_rank;
        if (!do_evict) begin
          count_d = count_q + 1'b1;
        end
      end else if (!same_off) begin
        for (int i = 0; i < MAX_TRACKERS; i++) begin
          if (ent_valid_q[i] && (ent_rank_q[i] > hit_rank)) begin
            ent_rank_d[i] = ent_rank_q[i] - 1'b1;
          end
        end
        ent_rank_d[hit_idx] = RANK_W'(count_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ent_valid_q <= '0;
      ent_rank_q  <= '{default: '0};
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      ent_valid_q <= ent_valid_d;
      ent_rank_q  <= ent_rank_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= access_address_i;
    end
    if (commit) begin
      if (!hit) begin
        ent_page_q[ins_idx] <= acc_page;
        ent_last_q[ins_idx] <= acc_off;
        ent_dir_q[ins_idx]  <= DIR_NONE;
      end else if (!same_off) begin
        ent_last_q[hit_idx] <= acc_off;
        ent_dir_q[hit_idx]  <= new_dir;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(ent_valid_q))
    else $error("tracker count out of step with valid bits");

  for (genvar g = 0; g < MAX_TRACKERS; g++) begin : g_rank_chk
    a_rank_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ent_valid_q[g] |-> (CNT_W'(ent_rank_q[g]) < count_q))
      else $error("tracker age rank beyond tracker count");
  end
`endif

endmodule

@@ hw/rtl/spt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream prefetch tracker run queue
// Short FIFO of stream runs between the tracker table and the issue stage.
// ----------------------------------------------------------------------------
module spt_queue import spt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  run_cmd_t push_cmd_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output run_cmd_t pop_cmd_o
);

  run_cmd_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] level_q, level_d;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (level_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (level_q != '0);
  assign pop_cmd_o    = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    level_d = level_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (do_pop && !do_push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_level_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("run queue level beyond depth");
`endif

endmodule

@@ hw/rtl/spt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream prefetch tracker issue stage
// Walks one stream run block by block and drives prefetch addresses through
// an output register.
// ----------------------------------------------------------------------------
module spt_back import spt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  run_cmd_t          cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] prefetch_address_o,
  output logic              last_of_run_o
);

  logic              active_q, active_d;
  logic [DEG_W-1:0]  left_q, left_d;
  logic              out_valid_q, out_valid_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [OFF_W-1:0]  pos_q, pos_d;
  dir_e              dir_q, dir_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              last_q, last_d;
  logic [OFF_W-1:0]  nxt_pos;
  logic              can_load;

  assign can_load    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = !active_q;
  assign nxt_pos     = (dir_q == DIR_UP) ? pos_q + 1'b1 : pos_q - 1'b1;

  assign out_valid_o        = out_valid_q;
  assign prefetch_address_o = addr_q;
  assign last_of_run_o      = last_q;

  always_comb begin
    active_d    = active_q;
    left_d      = left_q;
    out_valid_d = out_valid_q;
    page_d      = page_q;
    pos_d       = pos_q;
    dir_d       = dir_q;
    addr_d      = addr_q;
    last_d      = last_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (!active_q) begin
      if (cmd_valid_i) begin
        active_d = 1'b1;
        page_d   = cmd_i.page;
        pos_d    = cmd_i.off;
        dir_d    = cmd_i.dir;
        left_d   = cmd_i.count;
      end
    end else if (can_load) begin
      out_valid_d = 1'b1;
      addr_d      = {page_q, nxt_pos, BLOCK_SHIFT'(0)};
      last_d      = (left_q == DEG_W'(1));
      pos_d       = nxt_pos;
      left_d      = left_q - 1'b1;
      active_d    = (left_q != DEG_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    pos_q  <= pos_d;
    dir_q  <= dir_d;
    addr_q <= addr_d;
    last_q <= last_d;
  end

`ifndef SYNTHESIS
  a_mid_run_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> active_q)
    else $error("non-final prefetch shown with no run in progress");

  a_active_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (left_q != '0))
    else $error("run in progress with nothing left to issue");
`endif

endmodule

@@ hw/rtl/stream_prefetch_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream prefetch tracker
// Tracks demand page streams in an LRU tracker table and issues runs of
// block-aligned prefetch addresses once a step direction repeats.
//
// Request side: in_valid_i / in_ready_o with access_address_i. A request is
// taken when both are high; the front end then captures it, then matches and
// updates the table, and takes the next one only after that.
// Result side: out_valid_o / out_ready_i with prefetch_address_o and
// last_of_run_o. A confirmed stream request yields up to prefetch_degree
// addresses; the first passes through the run queue and the issue stage's
// output register, the rest follow one per cycle while out_ready_i is high,
// and a new run starts once the last one ends. A two-entry run queue lets
// the front end keep taking requests while the receiver stalls; when that
// queue is full the front end holds a confirmed request until a slot frees.
// Configuration: APB writes to active_trackers (0x0) and prefetch_degree
// (0x4), with a setup and an access phase, pready always high.
// Reset: tracker table empty, active_trackers 16, prefetch_degree 4.
// ----------------------------------------------------------------------------
module stream_prefetch_tracker import spt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ADDR_W-1:0]  access_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ADDR_W-1:0]  prefetch_address_o,
  output logic               last_of_run_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [CFG_W-1:0] active_trackers_q, active_trackers_d;
  logic [CFG_W-1:0] prefetch_degree_q, prefetch_degree_d;
  cfg_reg_e         reg_idx;
  logic             cfg_write;

  logic     fq_valid, fq_ready;
  run_cmd_t fq_cmd;
  logic     qb_valid, qb_ready;
  run_cmd_t qb_cmd;

  assign pready    = 1'b1;
  assign reg_idx   = cfg_reg_e'(paddr[PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    active_trackers_d = active_trackers_q;
    prefetch_degree_d = prefetch_degree_q;
    unique case (reg_idx)
      REG_ACTIVE_TRACKERS: begin
        prdata = DATA_W'(active_trackers_q);
        if (cfg_write) active_trackers_d = pwdata[CFG_W-1:0];
      end
      REG_PREFETCH_DEGREE: begin
        prdata = DATA_W'(prefetch_degree_q);
        if (cfg_write) prefetch_degree_d = pwdata[CFG_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_trackers_q <= ACTIVE_TRACKERS_RST;
      prefetch_degree_q <= PREFETCH_DEGREE_RST;
    end else begin
      active_trackers_q <= active_trackers_d;
      prefetch_degree_q <= prefetch_degree_d;
    end
  end

  spt_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .access_address_i  (access_address_i),
    .active_trackers_i (active_trackers_q),
    .prefetch_degree_i (prefetch_degree_q),
    .cmd_valid_o       (fq_valid),
    .cmd_ready_i       (fq_ready),
    .cmd_o             (fq_cmd)
  );

  spt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_cmd_i   (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_cmd_o    (qb_cmd)
  );

  spt_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (qb_valid),
    .cmd_ready_o        (qb_ready),
    .cmd_i              (qb_cmd),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .prefetch_address_o (prefetch_address_o),
    .last_of_run_o      (last_of_run_o)
  );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream prefetch tracker testbench
// Sends demand requests over valid/ready and keeps its own model of the LRU
// page tracker table. Every prefetch address and run marker is checked in
// order against that model. Covers directed streams, page edges, the tracker
// and degree limits, a shrunk tracker count, and random stream mixes under
// several register settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb import spt_pkg::*; ();

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned POOL_MAX      = 20;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last;
  } prefetch_t;

  typedef struct {
    logic [PAGE_W-1:0] page;
    int                pos;
    int                step;
  } stream_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_ready_o;
  logic [ADDR_W-1:0]  access_address_i = '0;
  logic               out_valid_o;
  logic               out_ready_i      = 1'b0;
  logic [ADDR_W-1:0]  prefetch_address_o;
  logic               last_of_run_o;
  logic               psel             = 1'b0;
  logic               penable          = 1'b0;
  logic               pwrite           = 1'b0;
  logic [PADDR_W-1:0] paddr            = '0;
  logic [DATA_W-1:0]  pwdata           = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  logic              trk_valid [MAX_TRACKERS];
  logic [PAGE_W-1:0] trk_page  [MAX_TRACKERS];
  logic [OFF_W-1:0]  trk_block [MAX_TRACKERS];
  dir_e              trk_dir   [MAX_TRACKERS];
  int unsigned       trk_rank  [MAX_TRACKERS];
  logic [CFG_W-1:0]  cfg_trackers = ACTIVE_TRACKERS_RST;
  logic [CFG_W-1:0]  cfg_degree   = PREFETCH_DEGREE_RST;

  prefetch_t   prefetch_q [$];
  stream_t     pool [POOL_MAX];
  int          error_count = 0;
  int unsigned idle_cycles = 0;
  int          ready_hold  = 0;
  bit          gaps_on     = 1'b1;
  bit          stalls_on   = 1'b1;

  stream_prefetch_tracker dut (.*);

  always #10 clk_i = ~clk_i;

  task automatic flag_error(input string what, input logic [ADDR_W-1:0] got,
                            input logic [ADDR_W-1:0] want);
    $display("ERROR %s: got %h, want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic int unsigned live_trackers();
    int unsigned n = 0;
    for (int i = 0; i < MAX_TRACKERS; i++) begin
      if (trk_valid[i]) n++;
    end
    return n;
  endfunction

  function automatic void age_above(input int unsigned r);
    for (int i = 0; i < MAX_TRACKERS; i++) begin
      if (trk_valid[i] && trk_rank[i] > r) trk_rank[i]--;
    end
  endfunction

  function automatic void track_access(input logic [ADDR_W-1:0] addr);
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  off;
    int                hit;
    int unsigned       n, limit, depth, room;
    dir_e              dir;
    bit                repeat_dir;
    prefetch_t         pf;
    page = addr[ADDR_W-1:PAGE_SHIFT];
    off  = addr[PAGE_SHIFT-1:BLOCK_SHIFT];
    hit  = -1;
    for (int i = MAX_TRACKERS - 1; i >= 0; i--) begin
      if (trk_valid[i] && trk_page[i] == page) hit = i;
    end
    if (hit < 0) begin
      limit = (cfg_trackers == 0) ? 1 :
              (cfg_trackers > MAX_TRACKERS) ? MAX_TRACKERS : cfg_trackers;
      n = live_trackers();
      if (n >= limit) begin
        for (int i = 0; i < MAX_TRACKERS; i++) begin
          if (trk_valid[i] && trk_rank[i] == 0) begin
            trk_valid[i] = 1'b0;
            age_above(0);
            n--;
            break;
          end
        end
      end
      for (int i = 0; i < MAX_TRACKERS; i++) begin
        if (!trk_valid[i]) begin
          trk_valid[i] = 1'b1;
          trk_page[i]  = page;
          trk_block[i] = off;
          trk_dir[i]   = DIR_NONE;
          trk_rank[i]  = n;
          break;
        end
      end
      return;
    end
    if (off == trk_block[hit]) return;
    dir = (off > trk_block[hit]) ? DIR_UP : DIR_DOWN;
    repeat_dir = (dir == trk_dir[hit]);
    trk_block[hit] = off;
    trk_dir[hit]   = dir;
    n = live_trackers();
    age_above(trk_rank[hit]);
    trk_rank[hit] = n - 1;
    if (!repeat_dir) return;
    depth = (cfg_degree > MAX_DEGREE) ? MAX_DEGREE : cfg_degree;
    room  = (dir == DIR_UP) ? BLOCKS_PER_PAGE - 1 - off : off;
    if (room < depth) depth = room;
    for (int i = 1; i <= depth; i++) begin
      pf.addr = {page, (dir == DIR_UP) ? off + OFF_W'(i) : off - OFF_W'(i),
                 {BLOCK_SHIFT{1'b0}}};
      pf.last = (i == depth);
      prefetch_q.insert(prefetch_q.size(), pf);
    end
  endfunction

  function automatic logic [PAGE_W-1:0] rand_page();
    return PAGE_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ADDR_W-1:0] block_addr(input logic [PAGE_W-1:0] page,
                                                   input int off);
    return {page, OFF_W'(off), BLOCK_SHIFT'($urandom)};
  endfunction

  task automatic issue_access(input logic [ADDR_W-1:0] addr);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    access_address_i <= addr;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    track_access(addr);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (prefetch_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ACTIVE_TRACKERS) cfg_trackers = value;
    else cfg_degree = value;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] trackers,
                            input logic [CFG_W-1:0] degree);
    wait_idle();
    write_reg(REG_ACTIVE_TRACKERS, trackers);
    write_reg(REG_PREFETCH_DEGREE, degree);
  endtask

  task automatic test_directed_streams();
    logic [PAGE_W-1:0] pg;
    int walk [6] = '{10, 11, 12, 12, 11, 10};
    // confirm up, same offset, turn around, confirm down
    pg = rand_page();
    foreach (walk[i]) issue_access(block_addr(pg, walk[i]));
    // top page edge: confirmed with no room left
    pg = '1;
    issue_access(block_addr(pg, 61));
    issue_access(block_addr(pg, 62));
    issue_access('1);
    // bottom page edge: partial run, then nothing
    pg = '0;
    issue_access(block_addr(pg, 3));
    issue_access(block_addr(pg, 2));
    issue_access(block_addr(pg, 1));
    issue_access('0);
  endtask

  task automatic test_limits();
    logic [PAGE_W-1:0] pg, other;
    // degree clamps to the maximum, zero trackers acts as one
    set_config(5'd0, 5'd31);
    pg    = rand_page();
    other = rand_page();
    issue_access(block_addr(pg, 20));
    issue_access(block_addr(pg, 21));
    issue_access(block_addr(pg, 22));
    issue_access(block_addr(other, 5));
    issue_access(block_addr(pg, 23));
    issue_access(block_addr(pg, 24));
    set_config(5'd0, 5'd0);
    issue_access(block_addr(pg, 25));
  endtask

  task automatic test_shrink();
    logic [PAGE_W-1:0] pg;
    set_config(5'd31, 5'd16);
    pg = rand_page();
    issue_access(block_addr(rand_page(), 7));
    issue_access(block_addr(pg, 40));
    issue_access(block_addr(rand_page(), 9));
    // a miss above the new limit drops only the oldest tracker
    set_config(5'd2, 5'd16);
    issue_access(block_addr(rand_page(), 0));
    issue_access(block_addr(pg, 41));
    issue_access(block_addr(pg, 42));
  endtask

  task automatic test_random_streams();
    logic [CFG_W-1:0] trackers_set [PHASES] =
      '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd4, 5'd16, 5'd8};
    logic [CFG_W-1:0] degree_set   [PHASES] =
      '{5'd4, 5'd16, 5'd17, 5'd1, 5'd0, 5'd8, 5'd31, 5'd2};
    int npool, s, r, stride, target;
    for (int p = 0; p < PHASES; p++) begin
      set_config(trackers_set[p], degree_set[p]);
      gaps_on   = (p % 4 == 0) || (p % 4 == 2);
      stalls_on = (p % 4 == 0) || (p % 4 == 1);
      npool = $urandom_range(2, POOL_MAX);
      for (int i = 0; i < npool; i++) begin
        pool[i].page = rand_page();
        pool[i].pos  = $urandom_range(0, BLOCKS_PER_PAGE - 1);
        pool[i].step = $urandom_range(0, 1) ? 1 : -1;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        s = $urandom_range(0, npool - 1);
        r = $urandom_range(0, 99);
        if (r < 6) begin
          issue_access({$urandom, $urandom});
          continue;
        end
        if (r < 72) begin
          stride = 1;
        end else if (r < 80) begin
          stride = $urandom_range(2, 4);
        end else if (r < 86) begin
          pool[s].step = -pool[s].step;
          stride = 1;
        end else if (r < 90) begin
          stride = 0;
        end else begin
          pool[s].pos = $urandom_range(0, BLOCKS_PER_PAGE - 1);
          stride = 0;
        end
        target = pool[s].pos + stride * pool[s].step;
        if (target < 0 || target >= int'(BLOCKS_PER_PAGE)) begin
          pool[s].step = -pool[s].step;
          target = pool[s].pos + pool[s].step;
        end
        pool[s].pos = target;
        issue_access(block_addr(pool[s].page, pool[s].pos));
        if ($urandom_range(0, 49) == 0) wait_idle();
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) ready_hold = stalls_on ? $urandom_range(0, 3) : 0;
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (prefetch_q.size() == 0) begin
        flag_error("unexpected prefetch_address", prefetch_address_o, '0);
      end else begin
        if (prefetch_address_o !== prefetch_q[0].addr)
          flag_error("prefetch_address", prefetch_address_o, prefetch_q[0].addr);
        if (last_of_run_o !== prefetch_q[0].last)
          flag_error("last_of_run", ADDR_W'(last_of_run_o), ADDR_W'(prefetch_q[0].last));
        prefetch_q.delete(0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("stream_prefetch_tracker: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_TRACKERS; i++) begin
      trk_valid[i] = 1'b0;
      trk_rank[i]  = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_streams();
    test_limits();
    test_shrink();
    test_random_streams();
    wait_idle();
    if (error_count == 0) begin
      $display("stream_prefetch_tracker: match");
    end else begin
      $display("stream_prefetch_tracker: mismatch");
    end
    $finish;
  end

endmodule

@@ stream_prefetch_tracker.f @@
hw/rtl/spt_pkg.sv
hw/rtl/spt_front.sv
hw/rtl/spt_queue.sv
hw/rtl/spt_back.sv
hw/rtl/stream_prefetch_tracker.sv
bench/tb.sv
